// ----- sv/tun_pkg.sv -----
// Package for the triangle unit normal block.
// Holds the fixed normalization widths and the payload type of the back pipeline.
// No dependencies.
package tun_pkg;

  localparam int MagW       = 30;
  localparam int SqW        = 2 * MagW;
  localparam int SumW       = SqW + 2;
  localparam int RootW      = SumW / 2;
  localparam int RemW       = RootW + 1;
  localparam int QuoW       = 15;
  localparam int DivNW      = MagW + QuoW + 1;
  localparam int DenW       = RootW + 1;
  localparam int NrmW       = 16;
  localparam int QueueDepth = 4;

  localparam logic [QuoW-1:0] NormOne = QuoW'(16384);

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 deg;
  } tun_vec_t;

endpackage

// ----- sv/tun_front.sv -----
// Front pipeline of the triangle unit normal block: edge vectors and exact cross product.
// Depends on nothing but its parameter.
module tun_front #(
  parameter int CoordW = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [9*CoordW-1:0]         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3*(2*CoordW+3)-1:0]   out_data_o
);
  localparam int EdgeW  = CoordW + 1;
  localparam int ProdW  = 2 * EdgeW;
  localparam int CrossW = ProdW + 1;

  logic en;
  logic v1_q, v2_q, v3_q;
  logic signed [EdgeW-1:0]  ea_d [3], eb_d [3], ea_q [3], eb_q [3];
  logic signed [ProdW-1:0]  pr_d [6], pr_q [6];
  logic signed [CrossW-1:0] cr_d [3], cr_q [3];

  assign en          = !v3_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v3_q;

  always_comb begin
    logic [CoordW-1:0] o, p, s;
    for (int i = 0; i < 3; i++) begin
      o = in_data_i[i*CoordW +: CoordW];
      p = in_data_i[(i+3)*CoordW +: CoordW];
      s = in_data_i[(i+6)*CoordW +: CoordW];
      ea_d[i] = $signed({p[CoordW-1], p}) - $signed({o[CoordW-1], o});
      eb_d[i] = $signed({s[CoordW-1], s}) - $signed({o[CoordW-1], o});
    end
  end

  always_comb begin
    pr_d[0] = ea_q[1] * eb_q[2];
    pr_d[1] = ea_q[2] * eb_q[1];
    pr_d[2] = ea_q[2] * eb_q[0];
    pr_d[3] = ea_q[0] * eb_q[2];
    pr_d[4] = ea_q[0] * eb_q[1];
    pr_d[5] = ea_q[1] * eb_q[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d[i] = $signed({pr_q[2*i][ProdW-1], pr_q[2*i]})
              - $signed({pr_q[2*i+1][ProdW-1], pr_q[2*i+1]});
      out_data_o[i*CrossW +: CrossW] = cr_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ea_q <= ea_d;
      eb_q <= eb_d;
      pr_q <= pr_d;
      cr_q <= cr_d;
    end
  end

endmodule

// ----- sv/tun_fifo.sv -----
// Short queue between the front and back pipelines of the triangle unit normal block.
// Depends on nothing but its parameters.
module tun_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != (PtrW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

endmodule

// ----- sv/tun_back.sv -----
// Back pipeline of the triangle unit normal block: scaling, square root and division.
// Depends on tun_pkg.
module tun_back #(
  parameter int CrossW = 35
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3*CrossW-1:0]         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3*tun_pkg::NrmW-1:0]  out_data_o,
  output logic                        out_deg_o
);
  import tun_pkg::*;

  localparam int TopW = $clog2(CrossW + 1);
  localparam int ShW  = CrossW + MagW;

  logic en;
  logic ov_q;

  logic              v1_q;
  logic [CrossW-1:0] mg_d [3], mg1_q [3], mg2_q [3];
  logic [2:0]        ng_d, ng1_q, ng2_q;
  logic              dg_d, dg1_q, dg2_q;

  logic              v2_q;
  logic [TopW-1:0]   top_d, top2_q;

  logic              v3_q;
  tun_vec_t          vec3_d, vec3_q;

  logic              v4_q;
  tun_vec_t          vec4_q;
  logic [SqW-1:0]    sq_d [3], sq4_q [3];

  logic              qv_q   [RootW+1];
  logic [RemW-1:0]   qrem_q [RootW+1];
  logic [RootW-1:0]  qroot_q[RootW+1];
  logic [SumW-1:0]   qval_q [RootW+1];
  tun_vec_t          qvec_q [RootW+1];

  logic                  dv_q   [QuoW+1];
  logic [2:0][DenW-1:0]  drem_q [QuoW+1];
  logic [2:0][QuoW-1:0]  dlow_q [QuoW+1];
  logic [2:0][QuoW-1:0]  dquo_q [QuoW+1];
  logic [DenW-1:0]       dden_q [QuoW+1];
  tun_vec_t              dvec_q [QuoW+1];

  logic [3*NrmW-1:0] od_d, od_q;
  logic              odg_q;

  assign en          = !ov_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_deg_o   = odg_q;

  always_comb begin
    logic [CrossW-1:0] c;
    for (int i = 0; i < 3; i++) begin
      c        = in_data_i[i*CrossW +: CrossW];
      ng_d[i]  = c[CrossW-1];
      mg_d[i]  = (c ^ {CrossW{ng_d[i]}}) + CrossW'(ng_d[i]);
    end
    dg_d = in_data_i == '0;
  end

  always_comb begin
    logic [CrossW-1:0] orw;
    orw   = mg1_q[0] | mg1_q[1] | mg1_q[2];
    top_d = '0;
    for (int j = 0; j < CrossW; j++) begin
      if (orw[j]) top_d = TopW'(j + 1);
    end
  end

  always_comb begin
    logic [ShW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh             = {mg2_q[i], {MagW{1'b0}}} >> top2_q;
      vec3_d.mag[i]  = sh[MagW-1:0];
    end
    vec3_d.neg = ng2_q;
    vec3_d.deg = dg2_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = vec3_q.mag[i] * vec3_q.mag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mg1_q  <= mg_d;
      ng1_q  <= ng_d;
      dg1_q  <= dg_d;
      mg2_q  <= mg1_q;
      ng2_q  <= ng1_q;
      dg2_q  <= dg1_q;
      top2_q <= top_d;
      vec3_q <= vec3_d;
      vec4_q <= vec3_q;
      sq4_q  <= sq_d;
    end
  end

  // Square root stage zero sums the squares; each later stage resolves one root bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q[0] <= 1'b0;
    end else if (en) begin
      qv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qrem_q[0]  <= '0;
      qroot_q[0] <= '0;
      qval_q[0]  <= SumW'(sq4_q[0]) + SumW'(sq4_q[1]) + SumW'(sq4_q[2]);
      qvec_q[0]  <= vec4_q;
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [RemW+1:0]  rn;
    logic [RemW+1:0]  tr;
    logic             ge;

    assign rn = {qrem_q[k], qval_q[k][SumW-1 -: 2]};
    assign tr = (RemW+2)'({qroot_q[k], 2'b01});
    assign ge = rn >= tr;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[k+1] <= 1'b0;
      end else if (en) begin
        qv_q[k+1] <= qv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        qrem_q[k+1]  <= ge ? RemW'(rn - tr) : RemW'(rn);
        qroot_q[k+1] <= {qroot_q[k][RootW-2:0], ge};
        qval_q[k+1]  <= {qval_q[k][SumW-3:0], 2'b00};
        qvec_q[k+1]  <= qvec_q[k];
      end
    end
  end

  // Division stage zero forms the rounded dividend; each later stage makes one quotient bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= qv_q[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DivNW-1:0] num;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num = (DivNW'(qvec_q[RootW].mag[i]) << QuoW) + DivNW'(qroot_q[RootW]);
        drem_q[0][i] <= DenW'(num[DivNW-1:QuoW]);
        dlow_q[0][i] <= num[QuoW-1:0];
        dquo_q[0][i] <= '0;
      end
      dden_q[0] <= {qroot_q[RootW], 1'b0};
      dvec_q[0] <= qvec_q[RootW];
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic [2:0][DenW:0] tn;
    logic [2:0]         ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tn[i] = {drem_q[k][i], dlow_q[k][i][QuoW-1]};
        ge[i] = tn[i] >= {1'b0, dden_q[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          drem_q[k+1][i] <= ge[i] ? DenW'(tn[i] - {1'b0, dden_q[k]}) : DenW'(tn[i]);
          dlow_q[k+1][i] <= {dlow_q[k][i][QuoW-2:0], 1'b0};
          dquo_q[k+1][i] <= {dquo_q[k][i][QuoW-2:0], ge[i]};
        end
        dden_q[k+1] <= dden_q[k];
        dvec_q[k+1] <= dvec_q[k];
      end
    end
  end

  always_comb begin
    logic [QuoW-1:0] q;
    logic [NrmW-1:0] u;
    for (int i = 0; i < 3; i++) begin
      q = (dquo_q[QuoW][i] > NormOne) ? NormOne : dquo_q[QuoW][i];
      u = NrmW'(q);
      if (dvec_q[QuoW].deg) begin
        od_d[i*NrmW +: NrmW] = '0;
      end else if (dvec_q[QuoW].neg[i]) begin
        od_d[i*NrmW +: NrmW] = -u;
      end else begin
        od_d[i*NrmW +: NrmW] = u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od_q  <= od_d;
      odg_q <= dvec_q[QuoW].deg;
    end
  end

endmodule

// ----- sv/triangle_unit_normal_top.sv -----
// Top level of the triangle unit normal block.
// Depends on tun_pkg, tun_front, tun_fifo and tun_back.
//
// Each input transaction carries an origin and two neighbor points in signed Q4.12 and
// yields one output transaction with the unit normal of (first - origin) x (second - origin)
// in signed Q2.14; tuser is raised and the components are zero when the cross product is
// zero. One transaction is taken every cycle unless the pipeline is stalled. Each passes the
// edge, product and cross product registers, the four-entry queue, and the back pipeline
// with its scaling, 31 square-root stages and 15 divider stages. Both sides stall
// independently; the queue absorbs front results while the output is held.
module triangle_unit_normal_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // origin_x, origin_y, origin_z, first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [3*tun_pkg::NrmW-1:0]               m_axis_tdata,
  // degenerate
  output logic                                     m_axis_tuser
);
  import tun_pkg::*;

  localparam int CrossW = 2 * COORD_WIDTH + 3;

  logic                  fq_valid, fq_ready;
  logic [3*CrossW-1:0]   fq_data;
  logic                  qb_valid, qb_ready;
  logic [3*CrossW-1:0]   qb_data;

  tun_front #(
    .CoordW (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata[9*COORD_WIDTH-1:0]),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_data_o  (fq_data)
  );

  tun_fifo #(
    .Width (3 * CrossW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_data_o  (qb_data)
  );

  tun_back #(
    .CrossW (CrossW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qb_valid),
    .in_ready_o  (qb_ready),
    .in_data_i   (qb_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_deg_o   (m_axis_tuser)
  );

endmodule
